// ===== rtl/cstrip_pkg.sv =====
// package for the c comment stripper
// holds character constants, the queue entry type and the whitespace test
// no dependencies
package cstrip_pkg;

  localparam logic [7:0] CharNewline   = 8'h0A;
  localparam logic [7:0] CharStar      = 8'h2A;
  localparam logic [7:0] CharSlash     = 8'h2F;
  localparam logic [7:0] CharSpace     = 8'h20;
  localparam logic [7:0] CharDquote    = 8'h22;
  localparam logic [7:0] CharSquote    = 8'h27;
  localparam logic [7:0] CharBackslash = 8'h5C;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);

  // one classified input item: an optional slash, an optional byte, a stream reset
  typedef struct packed {
    logic       pre_slash;
    logic       has_byte;
    logic [7:0] data;
    logic       clear;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0B) ||
           (b == 8'h0C) || (b == 8'h0D);
  endfunction

endpackage

// ===== rtl/cstrip_front.sv =====
// front end of the c comment stripper: lexer state machine
// classifies each input beat into at most one queue entry
// depends on cstrip_pkg
module cstrip_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic               queue_full_i,
  input  logic [7:0]         in_byte_i,
  input  logic               end_of_input_i,
  output cstrip_pkg::push_t  req_o
);
  import cstrip_pkg::*;

  typedef enum logic [8:0] {
    MODE_CODE    = 9'b000000001,
    MODE_SLASH   = 9'b000000010,
    MODE_LINE    = 9'b000000100,
    MODE_BLOCK   = 9'b000001000,
    MODE_STAR    = 9'b000010000,
    MODE_STR     = 9'b000100000,
    MODE_STR_ESC = 9'b001000000,
    MODE_CHR     = 9'b010000000,
    MODE_CHR_ESC = 9'b100000000
  } mode_e;

  mode_e  mode_q, mode_d;
  entry_t ent;
  logic   want;
  logic   accept;

  function automatic mode_e code_next(input logic [7:0] b);
    if (b == CharSlash) begin
      return MODE_SLASH;
    end else if (b == CharDquote) begin
      return MODE_STR;
    end else if (b == CharSquote) begin
      return MODE_CHR;
    end
    return MODE_CODE;
  endfunction

  assign accept = push_i && !queue_full_i;

  always_comb begin
    mode_d = mode_q;
    ent    = '0;
    want   = 1'b0;
    ent.data = in_byte_i;
    if (end_of_input_i) begin
      ent.pre_slash = (mode_q == MODE_SLASH);
      ent.clear     = 1'b1;
      want          = 1'b1;
      mode_d        = MODE_CODE;
    end else begin
      unique case (mode_q)
        MODE_SLASH: begin
          if (in_byte_i == CharSlash) begin
            mode_d = MODE_LINE;
          end else if (in_byte_i == CharStar) begin
            mode_d = MODE_BLOCK;
          end else begin
            want          = 1'b1;
            ent.pre_slash = 1'b1;
            ent.has_byte  = (in_byte_i != CharSlash);
            mode_d        = code_next(in_byte_i);
          end
        end
        MODE_LINE: begin
          if (in_byte_i == CharNewline) begin
            want         = 1'b1;
            ent.has_byte = 1'b1;
            mode_d       = MODE_CODE;
          end
        end
        MODE_BLOCK: begin
          if (in_byte_i == CharStar) begin
            mode_d = MODE_STAR;
          end
        end
        MODE_STAR: begin
          if (in_byte_i == CharSlash) begin
            want         = 1'b1;
            ent.has_byte = 1'b1;
            ent.data     = CharSpace;
            mode_d       = MODE_CODE;
          end else if (in_byte_i != CharStar) begin
            mode_d = MODE_BLOCK;
          end
        end
        MODE_STR: begin
          want         = 1'b1;
          ent.has_byte = 1'b1;
          if (in_byte_i == CharBackslash) begin
            mode_d = MODE_STR_ESC;
          end else if (in_byte_i == CharDquote) begin
            mode_d = MODE_CODE;
          end
        end
        MODE_STR_ESC: begin
          want         = 1'b1;
          ent.has_byte = 1'b1;
          mode_d       = MODE_STR;
        end
        MODE_CHR: begin
          want         = 1'b1;
          ent.has_byte = 1'b1;
          if (in_byte_i == CharBackslash) begin
            mode_d = MODE_CHR_ESC;
          end else if (in_byte_i == CharSquote) begin
            mode_d = MODE_CODE;
          end
        end
        MODE_CHR_ESC: begin
          want         = 1'b1;
          ent.has_byte = 1'b1;
          mode_d       = MODE_CHR;
        end
        default: begin
          want         = (in_byte_i != CharSlash);
          ent.has_byte = want;
          mode_d       = code_next(in_byte_i);
        end
      endcase
    end
  end

  assign req_o.valid = accept && want;
  assign req_o.entry = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_CODE;
    end else if (accept) begin
      mode_q <= mode_d;
    end
  end

endmodule

// ===== rtl/cstrip_queue.sv =====
// short entry queue between the lexer and the emitter
// first-word-fall-through, one write and one read per cycle; a write is refused while full
// depends on cstrip_pkg
module cstrip_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cstrip_pkg::push_t   req_i,
  output logic                full_o,
  output logic                head_valid_o,
  output cstrip_pkg::entry_t  head_o,
  input  logic                pop_i
);
  import cstrip_pkg::*;

  entry_t             slot_q [QueueDepth];
  logic [QueueAw-1:0] wr_q, rd_q;
  logic [QueueAw:0]   cnt_q;
  logic               do_push, do_pop;

  assign full_o       = (cnt_q == (QueueAw+1)'(QueueDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = slot_q[rd_q];
  assign do_push      = req_i.valid && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= req_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QueueAw'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QueueAw'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (QueueAw+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (QueueAw+1)'(1);
      end
    end
  end

endmodule

// ===== rtl/cstrip_back.sv =====
// back end of the c comment stripper: line prefix buffer and result buffer
// holds leading whitespace in a small memory and flushes it when text appears
// depends on cstrip_pkg
module cstrip_back #(
  parameter int unsigned PREFIX_DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  cstrip_pkg::entry_t  head_i,
  output logic                pop_o,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          out_byte_o,
  output logic                last_o
);
  import cstrip_pkg::*;

  localparam int unsigned CW = $clog2(PREFIX_DEPTH + 1);
  localparam int unsigned AW = $clog2(PREFIX_DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(PREFIX_DEPTH);

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_FLUSH = 2'b10
  } state_e;

  state_e        state_q, state_d;
  logic          text_q, text_d;
  logic          blank_q, blank_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic          slash_done_q, slash_done_d;

  logic [7:0]    mem_q [PREFIX_DEPTH];
  logic [7:0]    rd_data_q;
  logic          mem_we, rd_en;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] ptr_ext;

  logic [7:0]    ob_byte_q [2];
  logic          ob_last_q [2];
  logic          ob_wr_q, ob_rd_q;
  logic [1:0]    ob_cnt_q;
  logic          ob_full, ob_pop;

  logic          cur_is_slash, cur_has, cur_last, advance;
  logic [7:0]    cur_byte;
  logic          put, put_last;
  logic [7:0]    put_byte;

  assign ob_full      = (ob_cnt_q == 2'd2);
  assign cur_is_slash = head_i.pre_slash && !slash_done_q;
  assign cur_has      = cur_is_slash || head_i.has_byte;
  assign cur_byte     = cur_is_slash ? CharSlash : head_i.data;
  assign cur_last     = !(cur_is_slash && head_i.has_byte);
  assign ptr_ext      = CW'(ptr_q) + CW'(1);

  always_comb begin
    state_d      = state_q;
    text_d       = text_q;
    blank_d      = blank_q;
    cnt_d        = cnt_q;
    ptr_d        = ptr_q;
    slash_done_d = slash_done_q;
    mem_we       = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = '0;
    advance      = 1'b0;
    put          = 1'b0;
    put_byte     = cur_byte;
    put_last     = cur_last;
    pop_o        = 1'b0;
    unique case (state_q)
      ST_RUN: begin
        if (head_valid_i) begin
          if (!cur_has) begin
            advance = 1'b1;
          end else if (cur_byte == CharNewline) begin
            if (text_q || !blank_q) begin
              if (!ob_full) begin
                put     = 1'b1;
                advance = 1'b1;
                blank_d = !text_q;
                text_d  = 1'b0;
                cnt_d   = '0;
              end
            end else begin
              advance = 1'b1;
              text_d  = 1'b0;
              cnt_d   = '0;
            end
          end else if (!text_q && is_ws(cur_byte)) begin
            advance = 1'b1;
            if (cnt_q < DepthC) begin
              mem_we = 1'b1;
              cnt_d  = cnt_q + CW'(1);
            end
          end else if (!text_q && cnt_q != '0) begin
            state_d = ST_FLUSH;
            rd_en   = 1'b1;
            ptr_d   = '0;
          end else if (!ob_full) begin
            put     = 1'b1;
            advance = 1'b1;
            text_d  = 1'b1;
            cnt_d   = '0;
          end
          if (advance) begin
            if (cur_is_slash && head_i.has_byte) begin
              slash_done_d = 1'b1;
            end else begin
              pop_o        = 1'b1;
              slash_done_d = 1'b0;
              if (head_i.clear) begin
                text_d  = 1'b0;
                blank_d = 1'b0;
                cnt_d   = '0;
              end
            end
          end
        end
      end
      ST_FLUSH: begin
        if (!ob_full) begin
          put      = 1'b1;
          put_byte = rd_data_q;
          put_last = 1'b0;
          if (ptr_ext < cnt_q) begin
            ptr_d   = ptr_q + AW'(1);
            rd_en   = 1'b1;
            rd_addr = ptr_q + AW'(1);
          end else begin
            cnt_d   = '0;
            text_d  = 1'b1;
            state_d = ST_RUN;
          end
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  // prefix memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[cnt_q[AW-1:0]] <= cur_byte;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_RUN;
      text_q       <= 1'b0;
      blank_q      <= 1'b0;
      cnt_q        <= '0;
      ptr_q        <= '0;
      slash_done_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      text_q       <= text_d;
      blank_q      <= blank_d;
      cnt_q        <= cnt_d;
      ptr_q        <= ptr_d;
      slash_done_q <= slash_done_d;
    end
  end

  // two-entry result buffer
  assign empty      = (ob_cnt_q == 2'd0);
  assign ob_pop     = pop && !empty;
  assign out_byte_o = ob_byte_q[ob_rd_q];
  assign last_o     = ob_last_q[ob_rd_q];

  always_ff @(posedge clk_i) begin
    if (put) begin
      ob_byte_q[ob_wr_q] <= put_byte;
      ob_last_q[ob_wr_q] <= put_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_wr_q  <= 1'b0;
      ob_rd_q  <= 1'b0;
      ob_cnt_q <= 2'd0;
    end else begin
      if (put) begin
        ob_wr_q <= !ob_wr_q;
      end
      if (ob_pop) begin
        ob_rd_q <= !ob_rd_q;
      end
      if (put && !ob_pop) begin
        ob_cnt_q <= ob_cnt_q + 2'd1;
      end else if (ob_pop && !put) begin
        ob_cnt_q <= ob_cnt_q - 2'd1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthC)
    else $error("prefix count beyond depth");
  a_flush_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FLUSH |-> (cnt_q != '0) && (CW'(ptr_q) < cnt_q))
    else $error("flush pointer outside held prefix");
  a_put_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    put |-> !ob_full)
    else $error("result buffer overrun");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> head_valid_i && state_q == ST_RUN)
    else $error("entry popped while not processing");
`endif

endmodule

// ===== rtl/c_comment_stripper.sv =====
// c comment stripper: takes a c source byte stream, returns it without comments.
// Bytes are taken one per cycle while the queue is not full. A pending slash
// goes out ahead of its byte as a separate result; before the first text byte of a
// line that has held leading whitespace, the emitter reads the held bytes back one
// at a time through the single read port of the prefix memory. A four-entry
// queue between lexer and emitter absorbs short flushes, longer ones stall the input
// once it fills, and a two-entry result buffer decouples the output side.
// depends on cstrip_pkg, cstrip_front, cstrip_queue, cstrip_back
module c_comment_stripper #(
  parameter int unsigned PREFIX_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_input_i,
  input  logic       push,
  output logic       full,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  output logic       empty,
  input  logic       pop
);
  import cstrip_pkg::*;

  push_t  req;
  entry_t head;
  logic   head_valid;
  logic   head_pop;

  cstrip_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .queue_full_i   (full),
    .in_byte_i      (in_byte_i),
    .end_of_input_i (end_of_input_i),
    .req_o          (req)
  );

  cstrip_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (head_pop)
  );

  cstrip_back #(
    .PREFIX_DEPTH (PREFIX_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (head_pop),
    .empty        (empty),
    .pop          (pop),
    .out_byte_o   (out_byte_o),
    .last_o       (last_o)
  );

endmodule

// ===== dv/testbench.sv =====
// testbench for c_comment_stripper: streams directed and random c source text, predicts
// every output beat and checks it. depends on cstrip_pkg and the c_comment_stripper rtl
`timescale 1ns / 1ps

module testbench;
  import cstrip_pkg::*;

  localparam int unsigned PrefixDepth = 32;
  localparam logic [7:0] CharTab  = 8'h09;
  localparam logic [7:0] CharVtab = 8'h0B;
  localparam logic [7:0] CharFf   = 8'h0C;
  localparam logic [7:0] CharCr   = 8'h0D;

  typedef enum logic [3:0] {
    LexCode, LexSlash, LexLine, LexBlock, LexStar, LexStr, LexStrEsc, LexChr, LexChrEsc
  } lex_mode_e;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  class strip_scoreboard;
    lex_mode_e   mode;
    logic        line_text;
    logic        prev_blank;
    logic [7:0]  held [PrefixDepth];
    int unsigned held_cnt;
    out_beat_t   expected_q [$];
    logic [7:0]  step_q [$];
    int unsigned errors, bytes_in, ends_in, beats_out, overflow_hits;

    function new();
      restart();
      errors = 0;
      bytes_in = 0;
      ends_in = 0;
      beats_out = 0;
      overflow_hits = 0;
    endfunction

    function void restart();
      mode = LexCode;
      line_text = 1'b0;
      prev_blank = 1'b0;
      held_cnt = 0;
    endfunction

    function bit is_blank_char(logic [7:0] b);
      return b inside {CharSpace, CharTab, CharNewline, CharVtab, CharFf, CharCr};
    endfunction

    function void close_line();
      if (line_text) begin
        step_q.push_back(CharNewline);
        prev_blank = 1'b0;
      end else if (!prev_blank) begin
        step_q.push_back(CharNewline);
        prev_blank = 1'b1;
      end
      line_text = 1'b0;
      held_cnt = 0;
    endfunction

    function void emit_char(logic [7:0] b);
      if (b == CharNewline) begin
        close_line();
      end else if (!line_text && is_blank_char(b)) begin
        if (held_cnt < PrefixDepth) begin
          held[held_cnt] = b;
          held_cnt++;
        end else begin
          overflow_hits++;
        end
      end else begin
        if (!line_text) begin
          for (int i = 0; i < held_cnt; i++) step_q.push_back(held[i]);
          held_cnt = 0;
          line_text = 1'b1;
        end
        step_q.push_back(b);
      end
    endfunction

    function void code_char(logic [7:0] b);
      if (b == CharSlash) begin
        mode = LexSlash;
      end else begin
        emit_char(b);
        if (b == CharDquote) mode = LexStr;
        else if (b == CharSquote) mode = LexChr;
        else mode = LexCode;
      end
    endfunction

    function void note_input(logic [7:0] b, logic end_flag);
      out_beat_t beat;
      step_q.delete();
      if (end_flag) begin
        ends_in++;
        if (mode == LexSlash) emit_char(CharSlash);
        restart();
      end else begin
        bytes_in++;
        case (mode)
          LexSlash: begin
            if (b == CharSlash) begin
              mode = LexLine;
            end else if (b == CharStar) begin
              mode = LexBlock;
            end else begin
              mode = LexCode;
              emit_char(CharSlash);
              code_char(b);
            end
          end
          LexLine: begin
            if (b == CharNewline) begin
              emit_char(CharNewline);
              mode = LexCode;
            end
          end
          LexBlock: begin
            if (b == CharStar) mode = LexStar;
          end
          LexStar: begin
            if (b == CharSlash) begin
              mode = LexCode;
              emit_char(CharSpace);
            end else if (b != CharStar) begin
              mode = LexBlock;
            end
          end
          LexStr: begin
            emit_char(b);
            if (b == CharBackslash) mode = LexStrEsc;
            else if (b == CharDquote) mode = LexCode;
          end
          LexStrEsc: begin
            emit_char(b);
            mode = LexStr;
          end
          LexChr: begin
            emit_char(b);
            if (b == CharBackslash) mode = LexChrEsc;
            else if (b == CharSquote) mode = LexCode;
          end
          LexChrEsc: begin
            emit_char(b);
            mode = LexChr;
          end
          default: code_char(b);
        endcase
      end
      foreach (step_q[i]) begin
        beat.data = step_q[i];
        beat.last = (i == step_q.size() - 1);
        expected_q.push_back(beat);
      end
    endfunction

    function void check_result(logic [7:0] data, logic last);
      out_beat_t want;
      beats_out++;
      if (expected_q.size() == 0) begin
        $error("out_byte %02h arrived with nothing expected", data);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (data !== want.data) begin
          $error("out_byte: expected %02h, got %02h", want.data, data);
          errors++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last);
          errors++;
        end
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       end_of_input = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] out_byte;
  logic       last_o;
  logic       empty;
  logic       pop = 1'b0;

  strip_scoreboard sb;
  int unsigned burst_left = 0;
  int unsigned counted = 0;

  always #4 clk_i = ~clk_i;

  c_comment_stripper #(
    .PREFIX_DEPTH(PrefixDepth)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_byte_i     (in_byte),
    .end_of_input_i(end_of_input),
    .push          (push),
    .full          (full),
    .out_byte_o    (out_byte),
    .last_o        (last_o),
    .empty         (empty),
    .pop           (pop)
  );

  task automatic send_item(input logic [7:0] b, input logic end_flag);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        @(negedge clk_i);
        push <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk_i);
    push <= 1'b1;
    in_byte <= b;
    end_of_input <= end_flag;
    do @(posedge clk_i); while (full);
    sb.note_input(b, end_flag);
    counted++;
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0: return CharTab;
      1: return CharVtab;
      2: return CharFf;
      3: return CharCr;
      default: return CharSpace;
    endcase
  endfunction

  function automatic logic [7:0] pick_letter();
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  // one well-formed token with random content, or noise, or a cut-off stream
  task automatic random_token();
    logic [7:0]  q [$];
    int unsigned kind, n;
    logic        ends;
    ends = 1'b0;
    kind = $urandom_range(0, 99);
    if (kind < 22) begin
      n = $urandom_range(1, 6);
      repeat (n) q.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom_range(33, 126))
                                                          : pick_letter());
    end else if (kind < 32) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 4);
      repeat (n) q.push_back(pick_blank());
    end else if (kind < 44) begin
      q.push_back(CharNewline);
    end else if (kind < 52) begin
      q.push_back(CharSlash);
      q.push_back(CharSlash);
      n = $urandom_range(0, 5);
      repeat (n) q.push_back(($urandom_range(0, 2) == 0) ? CharStar : pick_letter());
      q.push_back(CharNewline);
    end else if (kind < 62) begin
      q.push_back(CharSlash);
      q.push_back(CharStar);
      n = $urandom_range(0, 6);
      repeat (n) begin
        case ($urandom_range(0, 4))
          0: q.push_back(CharStar);
          1: q.push_back(CharNewline);
          2: q.push_back(CharSlash);
          3: q.push_back(CharSpace);
          default: q.push_back(pick_letter());
        endcase
      end
      if ($urandom_range(0, 2) == 0) q.push_back(CharStar);
      q.push_back(CharStar);
      q.push_back(CharSlash);
    end else if (kind < 72) begin
      q.push_back(CharDquote);
      n = $urandom_range(0, 5);
      repeat (n) begin
        case ($urandom_range(0, 4))
          0: begin
            q.push_back(CharBackslash);
            q.push_back(8'($urandom_range(0, 255)));
          end
          1: q.push_back(CharNewline);
          2: q.push_back(CharSquote);
          3: q.push_back(CharSpace);
          default: q.push_back(pick_letter());
        endcase
      end
      q.push_back(CharDquote);
    end else if (kind < 78) begin
      q.push_back(CharSquote);
      if ($urandom_range(0, 1) == 0) q.push_back(CharBackslash);
      q.push_back(($urandom_range(0, 2) == 0) ? CharSquote : pick_letter());
      q.push_back(CharSquote);
    end else if (kind < 84) begin
      q.push_back(CharSlash);
      case ($urandom_range(0, 5))
        0: q.push_back(CharSpace);
        1: q.push_back(CharDquote);
        2: q.push_back(CharSquote);
        3: q.push_back(CharNewline);
        4: q.push_back(8'($urandom_range(0, 255)));
        default: q.push_back(pick_letter());
      endcase
    end else if (kind < 94) begin
      q.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 97) begin
      ends = 1'b1;
    end else begin
      case ($urandom_range(0, 3))
        0: q.push_back(CharSlash);
        1: begin
          q.push_back(CharSlash);
          q.push_back(CharStar);
          q.push_back(pick_letter());
        end
        2: begin
          q.push_back(CharDquote);
          q.push_back(pick_letter());
        end
        default: begin
          q.push_back(CharSlash);
          q.push_back(CharSlash);
        end
      endcase
      ends = 1'b1;
    end
    foreach (q[i]) send_item(q[i], 1'b0);
    if (ends) send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // receiver: changing stall style, plus one long hold-off to back up the input
  initial begin
    int unsigned cyc;
    int unsigned style;
    bit          held_off;
    cyc = 0;
    style = 0;
    held_off = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held_off && sb.bytes_in >= 90) begin
        held_off = 1'b1;
        @(negedge clk_i);
        pop <= 1'b0;
        repeat (250) @(negedge clk_i);
      end else begin
        if (cyc % 48 == 0) style = $urandom_range(0, 3);
        @(negedge clk_i);
        case (style)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(0, 1));
          2: pop <= ($urandom_range(0, 3) == 0);
          default: pop <= (cyc % 4 != 3);
        endcase
        cyc++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check_result(out_byte, last_o);
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    string s;
    sb = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // indent + block comment over a newline, slash before a string with an escaped quote,
    // newline inside a literal, escaped char literal, line comment, blank line collapse
    s = "\t /*\n*/x/\"\\\"\n\"'\\''//\n \n\n";
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(CharSlash, 1'b0);
    send_item(8'h00, 1'b1);

    while (counted < 270) random_token();
    @(negedge clk_i);
    push <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("%0d bytes and %0d end markers in, %0d beats out, %0d prefix overflow bytes",
             sb.bytes_in, sb.ends_in, sb.beats_out, sb.overflow_hits);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
